FILE: src/ifmt_pkg.sv
package ifmt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_CHARS      = 25;
    localparam int FILL_MAX       = 14;
    localparam int FILL_W         = $clog2(FILL_MAX + 1);
    localparam int HEX_BASE       = 16;
    localparam int DEC_BASE       = 10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_SDEC = 2'd1,
        KIND_UDEC = 2'd2,
        KIND_HEX  = 2'd3
    } t_kind;

    // operations of the shared digit shifter
    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD_DEC,
        DP_LOAD_HEX,
        DP_DABBLE,
        DP_SHIFT_DIGIT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DABBLE,
        S_NORM,
        S_FILL,
        S_SIGN_PRE,
        S_PAD,
        S_SIGN_POST,
        S_DIGIT,
        S_LIT
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
    } t_emit;

    function automatic logic [7:0] digit_glyph(input logic [3:0] nib);
        logic [7:0] g;
        if (nib < 4'(DEC_BASE)) begin
            g = CHAR_ZERO + 8'(nib);
        end else begin
            g = CHAR_LOW_A + 8'(nib) - 8'(DEC_BASE);
        end
        return g;
    endfunction

endpackage

FILE: src/ifmt_digits.sv
module ifmt_digits
    import ifmt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int NDIG       = 10
) (
    input  logic                  i_clk,
    input  t_dp_op                i_op,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic [3:0]            o_top
);

    localparam int BCD_W = NDIG * 4;

    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [BCD_W-1:0]      adj;

    // add-3 correction on every nibble before the doubling shift
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[k*4 +: 4] = (r_bcd[k*4 +: 4] >= 4'd5) ? r_bcd[k*4 +: 4] + 4'd3
                                                      : r_bcd[k*4 +: 4];
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        unique case (i_op)
            DP_HOLD: begin
            end
            DP_LOAD_DEC: begin
                n_bin = i_mag;
                n_bcd = '0;
            end
            DP_LOAD_HEX: begin
                n_bcd = '0;
                n_bcd[VALUE_BITS-1:0] = i_mag;
            end
            DP_DABBLE: begin
                n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
            end
            DP_SHIFT_DIGIT: begin
                n_bcd = {r_bcd[BCD_W-5:0], 4'h0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top = r_bcd[BCD_W-1 -: 4];

endmodule

FILE: src/ifmt_seq.sv
module ifmt_seq
    import ifmt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int NDIG       = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [VALUE_BITS-1:0] i_number,
    input  logic [7:0]            i_char_in,
    input  logic [7:0]            i_min_width,
    input  logic                  i_zero_fill,
    input  logic [3:0]            i_top,
    input  logic                  i_out_free,
    output t_dp_op                o_op,
    output logic [VALUE_BITS-1:0] o_mag,
    output t_emit                 o_emit
);

    localparam int NDIG_W = $clog2(NDIG + 1);
    localparam int CNT_W  = $clog2(VALUE_BITS);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [NDIG_W-1:0]   r_ndig;
    logic [FILL_W-1:0]   r_fill;
    logic                r_neg;
    logic                r_zfill;
    logic [7:0]          r_width;
    logic [7:0]          r_char;

    t_kind               kind;
    logic                accept;
    logic                neg_in;
    logic                norm_shift;
    logic [9:0]          diff;
    logic [5:0]          lim;
    logic [FILL_W-1:0]   fill_val;

    assign kind   = t_kind'(i_kind);
    assign accept = i_in_valid && (r_state == S_IDLE);
    assign neg_in = (kind == KIND_SDEC) && i_number[VALUE_BITS-1];
    assign o_mag  = neg_in ? (~i_number + VALUE_BITS'(1)) : i_number;

    // leading zero digit still on top of the shifter
    assign norm_shift = (i_top == 4'h0) && (r_ndig > NDIG_W'(1));

    // pad count: width - digits - sign, dropped outside 1..FILL_MAX, capped at MAX_CHARS - digits - sign
    always_comb begin
        diff = 10'(r_width) - 10'(r_ndig) - 10'(r_neg);
        lim  = 6'(MAX_CHARS) - 6'(r_ndig) - 6'(r_neg);
        if (diff[9] || diff == 10'd0 || diff > 10'(FILL_MAX)) begin
            fill_val = '0;
        end else if (diff[5:0] > lim) begin
            fill_val = FILL_W'(lim);
        end else begin
            fill_val = FILL_W'(diff[5:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (kind) inside
                        KIND_LIT:             n_state = S_LIT;
                        KIND_HEX:             n_state = S_NORM;
                        KIND_SDEC, KIND_UDEC: n_state = S_DABBLE;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_DABBLE: begin
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) n_state = S_NORM;
            end
            S_NORM: begin
                if (!norm_shift) n_state = S_FILL;
            end
            S_FILL: begin
                if (r_neg && r_zfill) n_state = S_SIGN_PRE;
                else if (fill_val != '0) n_state = S_PAD;
                else if (r_neg) n_state = S_SIGN_POST;
                else n_state = S_DIGIT;
            end
            S_SIGN_PRE: begin
                if (i_out_free) n_state = (r_fill != '0) ? S_PAD : S_DIGIT;
            end
            S_PAD: begin
                if (i_out_free && r_fill == FILL_W'(1)) begin
                    n_state = (r_neg && !r_zfill) ? S_SIGN_POST : S_DIGIT;
                end
            end
            S_SIGN_POST: begin
                if (i_out_free) n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_out_free && r_ndig == NDIG_W'(1)) n_state = S_IDLE;
            end
            S_LIT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_op         = DP_HOLD;
        o_emit.valid = 1'b0;
        o_emit.ch    = CHAR_SPACE;
        o_emit.last  = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (kind) inside
                        KIND_HEX:             o_op = DP_LOAD_HEX;
                        KIND_SDEC, KIND_UDEC: o_op = DP_LOAD_DEC;
                        default:              o_op = DP_HOLD;
                    endcase
                end
            end
            S_DABBLE: o_op = DP_DABBLE;
            S_NORM: begin
                if (norm_shift) o_op = DP_SHIFT_DIGIT;
            end
            S_FILL: begin
            end
            S_SIGN_PRE, S_SIGN_POST: begin
                o_emit.valid = i_out_free;
                o_emit.ch    = CHAR_MINUS;
            end
            S_PAD: begin
                o_emit.valid = i_out_free;
                o_emit.ch    = r_zfill ? CHAR_ZERO : CHAR_SPACE;
            end
            S_DIGIT: begin
                o_emit.valid = i_out_free;
                o_emit.ch    = digit_glyph(i_top);
                o_emit.last  = (r_ndig == NDIG_W'(1));
                if (i_out_free) o_op = DP_SHIFT_DIGIT;
            end
            S_LIT: begin
                o_emit.valid = i_out_free;
                o_emit.ch    = r_char;
                o_emit.last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ndig  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cnt  <= '0;
                        r_ndig <= NDIG_W'(NDIG);
                    end
                end
                S_DABBLE: r_cnt <= r_cnt + CNT_W'(1);
                S_NORM: begin
                    if (norm_shift) r_ndig <= r_ndig - NDIG_W'(1);
                end
                S_FILL: r_fill <= fill_val;
                S_PAD: begin
                    if (i_out_free) r_fill <= r_fill - FILL_W'(1);
                end
                S_DIGIT: begin
                    if (i_out_free) r_ndig <= r_ndig - NDIG_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg   <= neg_in;
            r_zfill <= i_zero_fill;
            r_width <= i_min_width;
            r_char  <= i_char_in;
        end
    end

    a_digit_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_ndig != '0))
        else $error("digit phase entered with no digits left");

    a_pad_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (r_fill != '0))
        else $error("pad phase entered with empty pad count");

    a_pad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(FILL_MAX)))
        else $error("pad count above limit");

    a_dabble_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DABBLE) |=> (r_state == S_DABBLE || r_state == S_NORM))
        else $error("conversion left early");

endmodule

FILE: src/integer_to_ascii_formatter_unit.sv
// Formats one word per item: a literal character, or a VALUE_BITS-bit number as signed
// decimal, unsigned decimal or lower-case hex with optional space or zero padding, sent
// out one character per word with the last one flagged. Decimal conversion runs a
// shift-and-add-3 loop on one shared digit shifter, one bit per cycle; then leading zero
// digits are shifted out one per cycle (up to NDIG-1, NDIG being the decimal digit count
// of the widest value) until a nonzero digit or the last digit is on top, the pad count
// is settled, and characters then go out one per cycle when the output is not stalled.
// Hex skips the conversion loop, and a literal goes straight to the output. Input stall
// is high until the last character of the current item has been handed to the output
// register.
module integer_to_ascii_formatter_unit
    import ifmt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [VALUE_BITS-1:0] i_number,
    input  logic [7:0]            i_char_in,
    input  logic [7:0]            i_min_width,
    input  logic                  i_zero_fill,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_char,
    output logic                  o_is_last
);

    localparam int NDIG = (VALUE_BITS * 1233) / 4096 + 1;

    t_dp_op                op;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            top;
    t_emit                 emit;
    logic                  out_free;

    logic                  r_out_valid;
    logic [7:0]            r_out_char;
    logic                  r_out_last;

    assign out_free = !r_out_valid || !i_out_stall;

    ifmt_seq #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_number    (i_number),
        .i_char_in   (i_char_in),
        .i_min_width (i_min_width),
        .i_zero_fill (i_zero_fill),
        .i_top       (top),
        .i_out_free  (out_free),
        .o_op        (op),
        .o_mag       (mag),
        .o_emit      (emit)
    );

    ifmt_digits #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_digits (
        .i_clk (i_clk),
        .i_op  (op),
        .i_mag (mag),
        .o_top (top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_char <= emit.ch;
            r_out_last <= emit.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_is_last   = r_out_last;

endmodule

FILE: tb/integer_to_ascii_formatter_unit_test.sv
module integer_to_ascii_formatter_unit_test;
    import ifmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HOLD_CYCLES = 300;
    localparam int  SETTLE_CYCLES = 64;
    localparam int  WORDS_PER_PHASE = 50;
    localparam int  MAX_PRINTED = 20;
    localparam time TIMEOUT_NS = 5_000_000;

    // Renders each accepted input word into the characters it should produce and
    // checks the output words against them in order.
    class char_ledger;
        logic [7:0] pending_char[$];
        logic       pending_last[$];
        int         errors;
        int         words_in;
        int         literal_words;
        int         chars_seen;

        function new();
            errors = 0;
            words_in = 0;
            literal_words = 0;
            chars_seen = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) begin
                $display("MISMATCH @%0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        function void note_word(t_kind kind, logic [31:0] number, logic [7:0] ch,
                                logic [7:0] width, logic zfill);
            string      glyphs;
            logic [7:0] rev[0:31];
            logic [7:0] field[$];
            logic [31:0] mag;
            logic [31:0] base;
            logic       neg;
            int         ndig;
            int         fill;
            glyphs = "0123456789abcdef";
            words_in++;
            if (kind == KIND_LIT) begin
                literal_words++;
                pending_char.push_back(ch);
                pending_last.push_back(1'b1);
                return;
            end
            base = (kind == KIND_HEX) ? 32'(HEX_BASE) : 32'(DEC_BASE);
            neg = (kind == KIND_SDEC) && number[31];
            mag = neg ? (~number + 32'd1) : number;
            ndig = 0;
            do begin
                rev[ndig] = glyphs[int'(mag % base)];
                mag = mag / base;
                ndig++;
            end while (mag != 0);
            fill = int'(width) - ndig - int'(neg);
            if (fill < 1 || fill > FILL_MAX) fill = 0;
            if (fill > MAX_CHARS - ndig - int'(neg)) fill = MAX_CHARS - ndig - int'(neg);
            // zero fill puts the sign ahead of the padding, space fill behind it
            if (neg && zfill) field.push_back(CHAR_MINUS);
            repeat (fill) field.push_back(zfill ? CHAR_ZERO : CHAR_SPACE);
            if (neg && !zfill) field.push_back(CHAR_MINUS);
            for (int i = ndig - 1; i >= 0; i--) field.push_back(rev[i]);
            foreach (field[k]) begin
                pending_char.push_back(field[k]);
                pending_last.push_back(k == field.size() - 1);
            end
        endfunction

        task check_result(logic [7:0] ch, logic last);
            logic [7:0] want_ch;
            logic       want_last;
            chars_seen++;
            if (pending_char.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
                return;
            end
            want_ch = pending_char.pop_front();
            want_last = pending_last.pop_front();
            if (ch !== want_ch) begin
                report($sformatf("char 0x%02h, wanted 0x%02h", ch, want_ch));
            end
            if (last !== want_last) begin
                report($sformatf("last=%0b on char 0x%02h, wanted %0b", last, ch, want_last));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = KIND_LIT;
    logic [31:0] i_number = '0;
    logic [7:0]  i_char_in = '0;
    logic [7:0]  i_min_width = '0;
    logic        i_zero_fill = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_is_last;

    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    char_ledger  ledger;

    integer_to_ascii_formatter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_number    (i_number),
        .i_char_in   (i_char_in),
        .i_min_width (i_min_width),
        .i_zero_fill (i_zero_fill),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_is_last   (o_is_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // output backpressure; a toggle of hold_req starts one long hold
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                ledger.note_word(t_kind'(i_kind), i_number, i_char_in, i_min_width,
                                 i_zero_fill);
            end
            if (o_out_valid && !i_out_stall) begin
                ledger.check_result(o_out_char, o_is_last);
            end
        end
    end

    // Called right after an edge; leaves valid high once the word is taken.
    task automatic offer_word(t_kind kind, logic [31:0] number, logic [7:0] ch,
                              logic [7:0] width, logic zfill);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_number <= number;
        i_char_in <= ch;
        i_min_width <= width;
        i_zero_fill <= zfill;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic offer_random_word();
        t_kind       kind;
        logic [31:0] number;
        logic [7:0]  width;
        kind = t_kind'($urandom_range(3));
        case ($urandom_range(7))
            0: number = 32'h0;
            1: number = $urandom_range(99);
            2: number = $urandom_range(999999);
            3: number = 32'h0 - $urandom_range(1000, 1);
            4: number = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            5: number = 32'hffff_ffff;
            default: number = $urandom;
        endcase
        // mostly widths near the digit count so that padding is exercised
        width = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(26));
        offer_word(kind, number, 8'($urandom), width, 1'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending_char.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        ledger = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // literals, extremes and the padding corner cases, back to back
        offer_word(KIND_LIT,  32'h0,         8'h00, 8'd0,   1'b0);
        offer_word(KIND_LIT,  32'hffff_ffff, 8'hff, 8'd255, 1'b1);
        offer_word(KIND_LIT,  32'h1234_5678, 8'h41, 8'd200, 1'b1);
        offer_word(KIND_SDEC, 32'h0,         8'h00, 8'd0,   1'b0);
        offer_word(KIND_UDEC, 32'h0,         8'h00, 8'd0,   1'b1);
        offer_word(KIND_HEX,  32'h0,         8'h00, 8'd8,   1'b1);
        offer_word(KIND_SDEC, 32'h8000_0000, 8'h00, 8'd25,  1'b1);
        offer_word(KIND_SDEC, 32'h8000_0000, 8'h00, 8'd25,  1'b0);
        offer_word(KIND_SDEC, 32'h8000_0000, 8'h00, 8'd26,  1'b1);
        offer_word(KIND_SDEC, 32'hffff_ffff, 8'h00, 8'd5,   1'b1);
        offer_word(KIND_SDEC, 32'hffff_ffff, 8'h00, 8'd5,   1'b0);
        offer_word(KIND_SDEC, 32'h7fff_ffff, 8'h00, 8'd0,   1'b0);
        offer_word(KIND_SDEC, 32'd5,         8'h00, 8'd3,   1'b1);
        offer_word(KIND_SDEC, 32'hffff_ff85, 8'h00, 8'd1,   1'b0);
        offer_word(KIND_UDEC, 32'hffff_ffff, 8'h00, 8'd255, 1'b1);
        offer_word(KIND_UDEC, 32'h0,         8'h00, 8'd15,  1'b1);
        offer_word(KIND_UDEC, 32'h0,         8'h00, 8'd16,  1'b0);
        offer_word(KIND_UDEC, 32'd12345,     8'h00, 8'd6,   1'b0);
        offer_word(KIND_UDEC, 32'd12345,     8'h00, 8'd5,   1'b1);
        offer_word(KIND_UDEC, 32'h8000_0000, 8'h00, 8'd11,  1'b1);
        offer_word(KIND_HEX,  32'hdead_beef, 8'h00, 8'd0,   1'b0);
        offer_word(KIND_HEX,  32'hffff_ffff, 8'h00, 8'd22,  1'b0);
        offer_word(KIND_HEX,  32'h1,         8'h00, 8'd255, 1'b1);
        offer_word(KIND_HEX,  32'h1,         8'h00, 8'd15,  1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 45; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 45; end
                default: begin sender_idle_pct = 26; stall_pct = 26; end
            endcase
            // long output hold while words keep coming in
            if (ph == 2) hold_req <= ~hold_req;
            repeat (WORDS_PER_PHASE) offer_random_word();
            wait_drained();
        end

        if (ledger.pending_char.size() != 0) begin
            ledger.report($sformatf("%0d chars never arrived", ledger.pending_char.size()));
        end
        $display("Covered %0d words (%0d literal) and %0d output chars across idle/stall mixes,",
                 ledger.words_in, ledger.literal_words, ledger.chars_seen);
        $display("one long output hold and full drains; %0d mismatches.", ledger.errors);
        if (ledger.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
